@@ rtl/i2c_master_byte_engine_macros.svh @@
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared concurrent assertion forms for the byte engine RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// Holds at every clock edge outside reset.
`define MBE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("byte engine invariant violated");

// Antecedent implies consequent in the same cycle.
`define MBE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte engine implication violated");

// Antecedent implies consequent in the next cycle.
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte engine sequence violated");

`endif

@@ rtl/i2c_mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Operation codes, phase numbers and hold times shared by the engine RTL.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

    // Command operation codes.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef logic [3:0] phase_t;
    typedef logic [2:0] tick_t;
    typedef logic [3:0] bit_cnt_t;

    // Phase numbers: idle plus the seven segment steps.
    localparam phase_t PH_IDLE = 4'd0;
    localparam phase_t PH_S1   = 4'd1;
    localparam phase_t PH_S2   = 4'd2;
    localparam phase_t PH_S3   = 4'd3;
    localparam phase_t PH_S4   = 4'd4;
    localparam phase_t PH_S5   = 4'd5;
    localparam phase_t PH_S6   = 4'd6;
    localparam phase_t PH_S7   = 4'd7;

    // Segment hold times in ticks.
    localparam tick_t HOLD_SHORT = 3'd2;
    localparam tick_t HOLD_MID   = 3'd3;
    localparam tick_t HOLD_LONG  = 3'd5;

    // Bits per byte.
    localparam bit_cnt_t BITS_PER_BYTE = 4'd8;

    // Beat widths.
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // Final phase of each operation.
    function automatic phase_t last_phase(input op_t op);
        phase_t p;
        case (op)
            OP_START: p = PH_S4;
            OP_STOP:  p = PH_S3;
            default:  p = PH_S7;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/i2c_master_byte_engine.sv @@
// The segment sequencer updates once per accepted beat, whose result beat is
// offered in the next cycle. Throughput: one tick beat per cycle unless stalled.
// A command runs 9 (stop), 12 (start), 93 (write) or 96 (read) tick beats.
// Reset: SCL and SDA released, engine idle, read byte and ACK flag cleared,
// no result beat pending.
// ----------------------------------------------------------------------------
// I2C master byte engine
// Plays start, stop, write and read commands onto open-drain SCL/SDA as
// fixed segments, one microsecond tick per input beat, one result per beat.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    // tdata: cmd_valid[0], operation[2:1], data_byte[10:3], send_ack[11],
    //        sda_in[12], zero fill [15:13]
    input  logic [i2c_mbe_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3],
    //        ack_received[4], read_data[12:5], zero fill [15:13]
    output logic [i2c_mbe_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);
    import i2c_mbe_pkg::*;

    // Input beat fields.
    logic       cmd_valid;
    op_t        operation;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
    logic       accept;

    // Engine state.
    phase_t     phase_reg, phase_next;
    tick_t      tick_count_reg, tick_count_next;
    bit_cnt_t   bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    op_t        current_op_reg, current_op_next;
    logic       ack_to_send_reg, ack_to_send_next;
    logic       ack_seen_reg, ack_seen_next;
    logic       scl_level_reg, scl_level_next;
    logic       sda_level_reg, sda_level_next;
    logic [7:0] last_read_reg, last_read_next;

    // Result register.
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tvalid_reg;

    // Per-tick working values.
    logic   busy;
    logic   done;
    logic   do_enter;
    phase_t step;
    tick_t  hold;

    assign cmd_valid = s_axis_tdata[0];
    assign operation = op_t'(s_axis_tdata[2:1]);
    assign data_byte = s_axis_tdata[10:3];
    assign send_ack  = s_axis_tdata[11];
    assign sda_in    = s_axis_tdata[12];

    // A new tick is taken whenever the result register is free or draining.
    assign s_axis_tready = !m_tvalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tvalid = m_tvalid_reg;

    // Segment sequencer: one tick of work per accepted beat.
    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        current_op_next  = current_op_reg;
        ack_to_send_next = ack_to_send_reg;
        ack_seen_next    = ack_seen_reg;
        scl_level_next   = scl_level_reg;
        sda_level_next   = sda_level_reg;
        last_read_next   = last_read_reg;
        busy             = 1'b0;
        done             = 1'b0;
        do_enter         = 1'b0;
        step             = phase_reg;
        hold             = HOLD_MID;

        if (phase_reg == PH_IDLE)
        begin
            // Idle: load a new command and enter its first segment.
            if (cmd_valid)
            begin
                current_op_next  = operation;
                ack_to_send_next = send_ack;
                bit_count_next   = '0;
                shift_next       = (operation == OP_WRITE) ? data_byte : 8'h00;
                step             = PH_S1;
                do_enter         = 1'b1;
                busy             = 1'b1;
            end
        end
        else
        begin
            busy = 1'b1;
            if (tick_count_reg != '0)
            begin
                tick_count_next = tick_count_reg - 3'd1;
            end
            else
            begin
                // Hold expired: choose the next segment, looping per bit.
                do_enter = 1'b1;
                if (current_op_reg == OP_WRITE && phase_reg == PH_S3)
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                    step = (bit_count_next < BITS_PER_BYTE) ? PH_S1 : PH_S4;
                end
                else if (current_op_reg == OP_READ && phase_reg == PH_S4)
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                    step = (bit_count_next < BITS_PER_BYTE) ? PH_S2 : PH_S5;
                end
                else
                begin
                    step = phase_reg + 4'd1;
                end
            end
        end

        // Apply the entered segment's line levels and hold time.
        if (do_enter)
        begin
            phase_next = step;
            case (current_op_next)
                OP_START:
                begin
                    case (step)
                        PH_S1:   scl_level_next = 1'b1;
                        PH_S2:   sda_level_next = 1'b1;
                        PH_S3:   sda_level_next = 1'b0;
                        default: scl_level_next = 1'b0;
                    endcase
                end
                OP_STOP:
                begin
                    case (step)
                        PH_S1:   sda_level_next = 1'b0;
                        PH_S2:   scl_level_next = 1'b1;
                        default: sda_level_next = 1'b1;
                    endcase
                end
                OP_WRITE:
                begin
                    case (step)
                        PH_S1: sda_level_next = shift_next[7];
                        PH_S2:
                        begin
                            scl_level_next = 1'b1;
                            hold           = HOLD_LONG;
                        end
                        PH_S3:
                        begin
                            scl_level_next = 1'b0;
                            hold           = HOLD_SHORT;
                            shift_next     = {shift_next[6:0], 1'b0};
                        end
                        PH_S4: sda_level_next = 1'b1;
                        PH_S5: scl_level_next = 1'b1;
                        PH_S6:
                        begin
                            ack_seen_next = ~sda_in;
                            hold          = HOLD_SHORT;
                        end
                        default:
                        begin
                            scl_level_next = 1'b0;
                            hold           = HOLD_LONG;
                        end
                    endcase
                end
                default:
                begin
                    case (step)
                        PH_S1: sda_level_next = 1'b1;
                        PH_S2: scl_level_next = 1'b1;
                        PH_S3:
                        begin
                            shift_next = {shift_next[6:0], sda_in};
                            hold       = HOLD_SHORT;
                        end
                        PH_S4:
                        begin
                            scl_level_next = 1'b0;
                            hold           = HOLD_LONG;
                        end
                        PH_S5:
                        begin
                            last_read_next = shift_next;
                            sda_level_next = ~ack_to_send_next;
                        end
                        PH_S6:
                        begin
                            scl_level_next = 1'b1;
                            hold           = HOLD_LONG;
                        end
                        default:
                        begin
                            scl_level_next = 1'b0;
                            hold           = HOLD_LONG;
                        end
                    endcase
                end
            endcase
            tick_count_next = hold - 3'd1;
        end

        // Final tick of the last segment ends the command.
        if (busy && tick_count_next == '0 && phase_next >= last_phase(current_op_next))
        begin
            done       = 1'b1;
            phase_next = PH_IDLE;
        end

        m_tdata_next = {3'b000, last_read_next, ack_seen_next, done, busy,
                        sda_level_next, scl_level_next};
    end

    // Engine state registers, updated once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            current_op_reg  <= OP_START;
            ack_to_send_reg <= 1'b0;
            ack_seen_reg    <= 1'b0;
            scl_level_reg   <= 1'b1;
            sda_level_reg   <= 1'b1;
            last_read_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            current_op_reg  <= current_op_next;
            ack_to_send_reg <= ack_to_send_next;
            ack_seen_reg    <= ack_seen_next;
            scl_level_reg   <= scl_level_next;
            sda_level_reg   <= sda_level_next;
            last_read_reg   <= last_read_next;
        end
    end

    // Result beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            m_tvalid_reg <= s_axis_tvalid;
        end
    end

    // Result beat payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Idle engine always has its hold counter drained.
    `MBE_ASSERT_IMPLIES(a_idle_tick_zero, clk, rst_n,
        phase_reg == PH_IDLE, tick_count_reg == '0)
    // The bit loop never runs past one byte.
    `MBE_ASSERT_ALWAYS(a_bit_count_range, clk, rst_n, bit_count_reg <= BITS_PER_BYTE)
    // A done beat is always a busy beat.
    `MBE_ASSERT_IMPLIES(a_done_busy, clk, rst_n,
        m_tvalid_reg && m_tdata_reg[3], m_tdata_reg[2])
    // Accepting a beat that ends a command leaves the engine idle.
    `MBE_ASSERT_NEXT(a_done_idle, clk, rst_n,
        accept && done, phase_reg == PH_IDLE)

endmodule

@@ dv/tb_i2c_master_byte_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master byte engine
// Drives one tick beat per item with the sampled SDA level and optional
// commands, predicts every result beat with a cycle-true model of the segment
// sequencer and compares each result field by field. Directed commands cover
// the byte and ACK extremes, commands while busy, idle ticks and back-to-back
// commands, then random start/data/stop transactions run under random stalls
// on both sides and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_i2c_master_byte_engine;

    import i2c_mbe_pkg::*;

    // Tick beats per command and where the engine samples SDA within them.
    localparam int TICKS_START    = 12;
    localparam int TICKS_STOP     = 9;
    localparam int TICKS_WRITE    = 93;
    localparam int TICKS_READ     = 96;
    localparam int WRITE_ACK_TICK = 86;
    localparam int READ_BIT0_TICK = 6;
    localparam int BIT_PERIOD     = 10;

    // Random transactions run until this many tick beats have been taken.
    localparam int RANDOM_ITEM_TARGET = 520;
    localparam int HOLD_OFF_CYCLES    = 200;
    localparam int TAIL_CYCLES        = 8;
    // About 700 tick beats, each at worst waiting out both longest gaps.
    localparam int CYCLE_LIMIT        = 200000;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rd_byte;
    } line_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    logic                 quiet = 1'b0;
    logic                 hold_off_req = 1'b0;
    int                   stall_left = 0;
    int                   err_count = 0;
    int                   commands_issued = 0;
    int                   ticks_accepted = 0;
    int                   results_checked = 0;
    int                   cycles = 0;

    line_state_t          expected_lines_q[$];
    line_state_t          want;

    // Model of the engine state.
    phase_t               mdl_phase;
    tick_t                mdl_ticks;
    bit_cnt_t             mdl_bits;
    logic [7:0]           mdl_shift;
    op_t                  mdl_op;
    logic                 mdl_ack_drive;
    logic                 mdl_ack_seen;
    logic                 mdl_scl;
    logic                 mdl_sda;
    logic [7:0]           mdl_rd_byte;

    i2c_master_byte_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit in case the engine hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly no gap, some short gaps and a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return 0;
        if (roll < 96)
            return $urandom_range(3, 1);
        return $urandom_range(24, 8);
    endfunction

    // ------------------------------------------------------------------------
    // Engine model
    // ------------------------------------------------------------------------

    task automatic reset_engine_model();
        mdl_phase     = PH_IDLE;
        mdl_ticks     = '0;
        mdl_bits      = '0;
        mdl_shift     = 8'h00;
        mdl_op        = OP_START;
        mdl_ack_drive = 1'b0;
        mdl_ack_seen  = 1'b0;
        mdl_scl       = 1'b1;
        mdl_sda       = 1'b1;
        mdl_rd_byte   = 8'h00;
    endtask

    // Apply the line change of a segment and load its hold count.
    function automatic void enter_segment(input phase_t step, input logic sda_now);
        tick_t hold;
        hold = HOLD_MID;
        mdl_phase = step;
        case (mdl_op)
            OP_START:
            begin
                if (step == PH_S1)
                    mdl_scl = 1'b1;
                else if (step == PH_S2)
                    mdl_sda = 1'b1;
                else if (step == PH_S3)
                    mdl_sda = 1'b0;
                else
                    mdl_scl = 1'b0;
            end
            OP_STOP:
            begin
                if (step == PH_S1)
                    mdl_sda = 1'b0;
                else if (step == PH_S2)
                    mdl_scl = 1'b1;
                else
                    mdl_sda = 1'b1;
            end
            OP_WRITE:
            begin
                case (step)
                    PH_S1: mdl_sda = mdl_shift[7];
                    PH_S2:
                    begin
                        mdl_scl = 1'b1;
                        hold = HOLD_LONG;
                    end
                    PH_S3:
                    begin
                        mdl_scl = 1'b0;
                        hold = HOLD_SHORT;
                        mdl_shift = {mdl_shift[6:0], 1'b0};
                    end
                    PH_S4: mdl_sda = 1'b1;
                    PH_S5: mdl_scl = 1'b1;
                    PH_S6:
                    begin
                        mdl_ack_seen = ~sda_now;
                        hold = HOLD_SHORT;
                    end
                    default:
                    begin
                        mdl_scl = 1'b0;
                        hold = HOLD_LONG;
                    end
                endcase
            end
            default:
            begin
                case (step)
                    PH_S1: mdl_sda = 1'b1;
                    PH_S2: mdl_scl = 1'b1;
                    PH_S3:
                    begin
                        mdl_shift = {mdl_shift[6:0], sda_now};
                        hold = HOLD_SHORT;
                    end
                    PH_S4:
                    begin
                        mdl_scl = 1'b0;
                        hold = HOLD_LONG;
                    end
                    PH_S5:
                    begin
                        mdl_rd_byte = mdl_shift;
                        mdl_sda = ~mdl_ack_drive;
                    end
                    PH_S6:
                    begin
                        mdl_scl = 1'b1;
                        hold = HOLD_LONG;
                    end
                    default:
                    begin
                        mdl_scl = 1'b0;
                        hold = HOLD_LONG;
                    end
                endcase
            end
        endcase
        mdl_ticks = hold - 3'd1;
    endfunction

    // Segment that follows the current one; data segments loop per bit.
    function automatic phase_t following_segment(input phase_t step);
        if (mdl_op == OP_WRITE && step == PH_S3)
        begin
            mdl_bits = mdl_bits + 4'd1;
            return (mdl_bits < BITS_PER_BYTE) ? PH_S1 : PH_S4;
        end
        if (mdl_op == OP_READ && step == PH_S4)
        begin
            mdl_bits = mdl_bits + 4'd1;
            return (mdl_bits < BITS_PER_BYTE) ? PH_S2 : PH_S5;
        end
        return step + 4'd1;
    endfunction

    // Advance the engine by one tick beat and return the line state it gives.
    function automatic line_state_t predict_lines(input logic [IN_W-1:0] beat);
        logic        cmd_valid;
        op_t         cmd_op;
        logic [7:0]  cmd_byte;
        logic        cmd_ack;
        logic        sda_now;
        logic        busy;
        logic        done;
        phase_t      final_step;
        line_state_t res;
        cmd_valid = beat[0];
        cmd_op    = op_t'(beat[2:1]);
        cmd_byte  = beat[10:3];
        cmd_ack   = beat[11];
        sda_now   = beat[12];
        busy      = 1'b0;
        done      = 1'b0;
        if (mdl_phase == PH_IDLE)
        begin
            if (cmd_valid)
            begin
                mdl_op        = cmd_op;
                mdl_ack_drive = cmd_ack;
                mdl_bits      = '0;
                mdl_shift     = (cmd_op == OP_WRITE) ? cmd_byte : 8'h00;
                enter_segment(PH_S1, sda_now);
                busy = 1'b1;
            end
        end
        else
        begin
            busy = 1'b1;
            if (mdl_ticks != '0)
                mdl_ticks = mdl_ticks - 3'd1;
            else
                enter_segment(following_segment(mdl_phase), sda_now);
        end
        final_step = (mdl_op == OP_START) ? PH_S4 : (mdl_op == OP_STOP) ? PH_S3 : PH_S7;
        if (busy && mdl_ticks == '0 && mdl_phase >= final_step)
        begin
            done = 1'b1;
            mdl_phase = PH_IDLE;
        end
        res.scl     = mdl_scl;
        res.sda     = mdl_sda;
        res.busy    = busy;
        res.done    = done;
        res.ack     = mdl_ack_seen;
        res.rd_byte = mdl_rd_byte;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            err_count++;
        end
    endtask

    // Check result beats first, then queue the prediction for an accepted tick.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (expected_lines_q.size() == 0)
                begin
                    $error("Result beat %h arrived with nothing expected.", m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    want = expected_lines_q.pop_front();
                    check_field("scl_out", want.scl, m_axis_tdata[0]);
                    check_field("sda_out", want.sda, m_axis_tdata[1]);
                    check_field("busy_res", want.busy, m_axis_tdata[2]);
                    check_field("done_res", want.done, m_axis_tdata[3]);
                    check_field("ack_received", want.ack, m_axis_tdata[4]);
                    check_field("read_data", want.rd_byte, m_axis_tdata[12:5]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                ticks_accepted++;
                expected_lines_q.push_back(predict_lines(s_axis_tdata));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        int gap;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off_req)
        begin
            hold_off_req <= 1'b0;
            stall_left <= HOLD_OFF_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            gap = quiet ? 0 : pick_gap();
            if (gap > 0)
            begin
                stall_left <= gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one tick beat and wait until it is taken.
    task automatic send_tick(input logic cmd_valid, input op_t op, input logic [7:0] data_byte,
                             input logic send_ack, input logic sda_in);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {3'b000, sda_in, send_ack, data_byte, op, cmd_valid};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_ticks(input int count);
        repeat (count)
            send_tick(1'b0, op_t'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Play out one command: the command beat, then filler ticks until its end.
    // Filler beats carry a command with the given percentage; the engine is
    // busy then and must ignore it. The slave answers through sda_in.
    task automatic drive_command(input op_t op, input logic [7:0] wr_byte, input logic ack_out,
                                 input logic [7:0] slave_byte, input logic slave_ack,
                                 input int noise_pct);
        int   len;
        int   bit_idx;
        logic sda;
        case (op)
            OP_START: len = TICKS_START;
            OP_STOP:  len = TICKS_STOP;
            OP_WRITE: len = TICKS_WRITE;
            default:  len = TICKS_READ;
        endcase
        for (int t = 0; t < len; t++)
        begin
            sda = 1'($urandom_range(1));
            if (op == OP_WRITE && t == WRITE_ACK_TICK)
                sda = ~slave_ack;
            if (op == OP_READ && t >= READ_BIT0_TICK && (t - READ_BIT0_TICK) % BIT_PERIOD == 0)
            begin
                bit_idx = (t - READ_BIT0_TICK) / BIT_PERIOD;
                if (bit_idx < 8)
                    sda = slave_byte[7 - bit_idx];
            end
            if (t == 0)
                send_tick(1'b1, op, wr_byte, ack_out, sda);
            else
                send_tick($urandom_range(99) < noise_pct, op_t'($urandom_range(3)),
                          8'($urandom_range(255)), 1'($urandom_range(1)), sda);
        end
        commands_issued++;
    endtask

    task automatic random_data_command(input int noise_pct);
        drive_command($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), noise_pct);
    endtask

    // Stop offering and wait until every accepted tick has its result.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_lines_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // After reset both lines stay released while no command is offered.
    task automatic test_idle_lines();
        idle_ticks(6);
    endtask

    // An all-ones byte written and refused, an all-zeros byte read and
    // acknowledged, and commands offered while busy.
    task automatic test_directed_commands();
        drive_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        drive_command(OP_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b0, 50);
        idle_ticks(3);
        drive_command(OP_READ, 8'hFF, 1'b1, 8'h00, 1'b0, 100);
        drive_command(OP_STOP, 8'hFF, 1'b1, 8'h00, 1'b0, 100);
        idle_ticks(4);
    endtask

    // Each command starts on the tick right after the previous one is done,
    // with neither side idling.
    task automatic test_back_to_back();
        quiet = 1'b1;
        drive_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        drive_command(OP_WRITE, 8'h00, 1'b0, 8'h00, 1'b1, 0);
        drive_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        drive_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        quiet = 1'b0;
    endtask

    // The result side holds off for a long stretch while ticks keep coming,
    // so the engine fills up and stalls its input.
    task automatic test_output_holdoff();
        hold_off_req <= 1'b1;
        drive_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 10);
        drive_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 10);
    endtask

    // The sender pauses until every result is in, then resumes.
    task automatic test_drain_pause();
        wait_drained();
        drive_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        wait_drained();
        drive_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 0);
    endtask

    // Mostly well-formed transactions with random bytes and slave answers,
    // the rest stray commands in any order.
    task automatic test_random_transactions();
        while (ticks_accepted < RANDOM_ITEM_TARGET)
        begin
            if ($urandom_range(99) < 85)
            begin
                drive_command(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              8'h00, 1'b0, 10);
                if ($urandom_range(99) < 20)
                    idle_ticks($urandom_range(5, 1));
                random_data_command(10);
                drive_command(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              8'h00, 1'b0, 10);
            end
            else
                drive_command(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 30);
            if ($urandom_range(99) < 30)
                idle_ticks($urandom_range(6, 1));
        end
    endtask

    // Reset, run the tests in turn, drain and report.
    initial
    begin
        reset_engine_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_lines();
        test_directed_commands();
        test_back_to_back();
        test_output_holdoff();
        test_drain_pause();
        test_random_transactions();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands over %0d tick beats; %0d result beats checked.",
                 commands_issued, ticks_accepted, results_checked);
        $display("Included idle ticks, commands while busy, back-to-back commands, "
                 , "random stalls and a long output hold-off.");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
